>>> src/interval_multiply_with_error_term_defines.svh
// Assertion macros for the interval multiplier checker.
// No dependencies; included by the checker file only.
`ifndef INTERVAL_MULTIPLY_WITH_ERROR_TERM_DEFINES_SVH
`define INTERVAL_MULTIPLY_WITH_ERROR_TERM_DEFINES_SVH

// checked out of reset only
`define IMWET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define IMWET_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/imwet_pkg.sv
// Shared types and constants for the interval multiplier.
// No dependencies.
package imwet_pkg;

  localparam int unsigned IN_W     = 32;
  localparam int unsigned OUT_W    = 64;
  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned MODE_W   = 2;
  // error magnitude always fits one bit less than the input word
  localparam int unsigned MAG_W    = IN_W - 1;
  localparam int unsigned NSTG     = 6;

  typedef enum logic [0:0] {
    CFG_ERROR_FACTOR    = 1'b0,
    CFG_CONSTANT_OFFSET = 1'b1
  } cfg_idx_e;

  localparam logic [FACTOR_W-1:0] ERROR_FACTOR_RST    = '0;
  localparam logic [OFFSET_W-1:0] CONSTANT_OFFSET_RST = OFFSET_W'(1);

  localparam logic [MODE_W-1:0] MODE_PLAIN   = 2'd0;
  localparam int unsigned       MODE_OFS_BIT = 1;

  typedef enum logic [1:0] {
    CLS_NONNEG,
    CLS_NONPOS,
    CLS_STRADDLE
  } cls_e;

  // load enables, one per pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

endpackage

>>> src/imwet_cfg.sv
// Configuration registers: error factor and constant offset.
// Depends on imwet_pkg.
module imwet_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_index_i,
  input  logic [imwet_pkg::CFG_W-1:0]     cfg_data_i,
  output logic [imwet_pkg::FACTOR_W-1:0]  error_factor_o,
  output logic [imwet_pkg::OFFSET_W-1:0]  constant_offset_o
);

  logic [imwet_pkg::FACTOR_W-1:0] factor_q;
  logic [imwet_pkg::OFFSET_W-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= imwet_pkg::ERROR_FACTOR_RST;
      offset_q <= imwet_pkg::CONSTANT_OFFSET_RST;
    end else if (cfg_we_i) begin
      case (imwet_pkg::cfg_idx_e'(cfg_index_i))
        imwet_pkg::CFG_ERROR_FACTOR: begin
          factor_q <= cfg_data_i[imwet_pkg::FACTOR_W-1:0];
        end
        imwet_pkg::CFG_CONSTANT_OFFSET: begin
          offset_q <= cfg_data_i[imwet_pkg::OFFSET_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign error_factor_o    = factor_q;
  assign constant_offset_o = offset_q;

endmodule

>>> src/imwet_prod.sv
// Cross products and bound selection (stages 1-2), delayed to stage 4.
// Depends on imwet_pkg.
module imwet_prod (
  input  logic                                clk_i,
  input  imwet_pkg::stage_en_t                en_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   b_neg_low_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   b_high_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   c_neg_low_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   c_high_i,
  output logic signed [imwet_pkg::OUT_W-1:0]  lo_o,
  output logic signed [imwet_pkg::OUT_W-1:0]  hi_o
);

  // p_xy = b_x * c_y, l = negated low, h = high
  logic signed [imwet_pkg::OUT_W-1:0] p_ll_d, p_lh_d, p_hl_d, p_hh_d;
  logic signed [imwet_pkg::OUT_W-1:0] p_ll_q, p_lh_q, p_hl_q, p_hh_q;
  imwet_pkg::cls_e                    b_cls_d, c_cls_d, b_cls_q, c_cls_q;
  logic signed [imwet_pkg::OUT_W-1:0] lo_d, hi_d;
  logic signed [imwet_pkg::OUT_W-1:0] lo2_q, hi2_q, lo3_q, hi3_q, lo4_q, hi4_q;

  assign p_ll_d = b_neg_low_i * c_neg_low_i;
  assign p_lh_d = b_neg_low_i * c_high_i;
  assign p_hl_d = b_high_i * c_neg_low_i;
  assign p_hh_d = b_high_i * c_high_i;

  always_comb begin
    if (b_neg_low_i <= 32'sd0) begin
      b_cls_d = imwet_pkg::CLS_NONNEG;
    end else if (b_high_i <= 32'sd0) begin
      b_cls_d = imwet_pkg::CLS_NONPOS;
    end else begin
      b_cls_d = imwet_pkg::CLS_STRADDLE;
    end
    if (c_neg_low_i <= 32'sd0) begin
      c_cls_d = imwet_pkg::CLS_NONNEG;
    end else if (c_high_i <= 32'sd0) begin
      c_cls_d = imwet_pkg::CLS_NONPOS;
    end else begin
      c_cls_d = imwet_pkg::CLS_STRADDLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      p_ll_q  <= p_ll_d;
      p_lh_q  <= p_lh_d;
      p_hl_q  <= p_hl_d;
      p_hh_q  <= p_hh_d;
      b_cls_q <= b_cls_d;
      c_cls_q <= c_cls_d;
    end
  end

  // negation never overflows: |p| <= 2^62
  always_comb begin
    lo_d = p_hl_q;
    hi_d = p_hh_q;
    case (c_cls_q)
      imwet_pkg::CLS_NONNEG: begin
        case (b_cls_q)
          imwet_pkg::CLS_NONNEG: begin
            lo_d = -p_ll_q;
            hi_d = p_hh_q;
          end
          imwet_pkg::CLS_NONPOS: begin
            lo_d = p_lh_q;
            hi_d = -p_hl_q;
          end
          default: begin
            lo_d = p_lh_q;
            hi_d = p_hh_q;
          end
        endcase
      end
      imwet_pkg::CLS_NONPOS: begin
        case (b_cls_q)
          imwet_pkg::CLS_NONNEG: begin
            lo_d = p_hl_q;
            hi_d = -p_lh_q;
          end
          imwet_pkg::CLS_NONPOS: begin
            lo_d = -p_hh_q;
            hi_d = p_ll_q;
          end
          default: begin
            lo_d = p_hl_q;
            hi_d = p_ll_q;
          end
        endcase
      end
      default: begin
        case (b_cls_q)
          imwet_pkg::CLS_NONNEG: begin
            lo_d = p_hl_q;
            hi_d = p_hh_q;
          end
          imwet_pkg::CLS_NONPOS: begin
            lo_d = p_lh_q;
            hi_d = p_ll_q;
          end
          default: begin
            lo_d = (p_hl_q > p_lh_q) ? p_hl_q : p_lh_q;
            hi_d = (p_ll_q > p_hh_q) ? p_ll_q : p_hh_q;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      lo2_q <= lo_d;
      hi2_q <= hi_d;
    end
    if (en_i.s3) begin
      lo3_q <= lo2_q;
      hi3_q <= hi2_q;
    end
    if (en_i.s4) begin
      lo4_q <= lo3_q;
      hi4_q <= hi3_q;
    end
  end

  assign lo_o = lo4_q;
  assign hi_o = hi4_q;

endmodule

>>> src/imwet_err.sv
// Error term path: max|c|, scaling by the factor, rounding up, times b (stages 1-4).
// Depends on imwet_pkg.
module imwet_err (
  input  logic                                clk_i,
  input  imwet_pkg::stage_en_t                en_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   b_neg_low_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   b_high_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   c_neg_low_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   c_high_i,
  input  logic [imwet_pkg::FACTOR_W-1:0]      error_factor_i,
  output logic signed [imwet_pkg::OUT_W-1:0]  term_o
);

  localparam int unsigned EFP_W = imwet_pkg::IN_W + imwet_pkg::FACTOR_W;
  localparam logic [EFP_W-1:0] RND = {{imwet_pkg::IN_W{1'b0}}, {imwet_pkg::FACTOR_W{1'b1}}};

  logic [imwet_pkg::IN_W-1:0]         abs_l, abs_h, amax_d, amax_q;
  logic signed [imwet_pkg::IN_W-1:0]  sel_d, sel1_q, sel2_q, sel3_q;
  logic [EFP_W-1:0]                   efp_d, efp_q, efp_rnd;
  logic [imwet_pkg::MAG_W-1:0]        mag_d, mag_q;
  logic signed [imwet_pkg::OUT_W-1:0] term_d, term_q;

  // stage 1: magnitude of c and the b bound the term scales
  always_comb begin
    abs_l  = c_neg_low_i[imwet_pkg::IN_W-1] ? (~c_neg_low_i + 32'd1) : c_neg_low_i;
    abs_h  = c_high_i[imwet_pkg::IN_W-1] ? (~c_high_i + 32'd1) : c_high_i;
    amax_d = (abs_l > abs_h) ? abs_l : abs_h;
    if (b_neg_low_i <= 32'sd0) begin
      sel_d = b_high_i;
    end else if (b_high_i <= 32'sd0) begin
      sel_d = b_neg_low_i;
    end else begin
      sel_d = (b_neg_low_i > b_high_i) ? b_neg_low_i : b_high_i;
    end
  end

  assign efp_d   = amax_q * error_factor_i;
  assign efp_rnd = efp_q + RND;
  assign mag_d   = efp_rnd[imwet_pkg::FACTOR_W +: imwet_pkg::MAG_W];
  assign term_d  = $signed({1'b0, mag_q}) * sel3_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      amax_q <= amax_d;
      sel1_q <= sel_d;
    end
    if (en_i.s2) begin
      efp_q  <= efp_d;
      sel2_q <= sel1_q;
    end
    if (en_i.s3) begin
      mag_q  <= mag_d;
      sel3_q <= sel2_q;
    end
    if (en_i.s4) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

>>> src/imwet_sat.sv
// Saturating additions of error term (stage 5) and offset (stage 6).
// Depends on imwet_pkg.
module imwet_sat (
  input  logic                                clk_i,
  input  imwet_pkg::stage_en_t                en_i,
  input  logic signed [imwet_pkg::OUT_W-1:0]  lo_i,
  input  logic signed [imwet_pkg::OUT_W-1:0]  hi_i,
  input  logic signed [imwet_pkg::OUT_W-1:0]  term_i,
  input  logic                                err_en_i,
  input  logic                                ofs_en_i,
  input  logic [imwet_pkg::OFFSET_W-1:0]      constant_offset_i,
  output logic signed [imwet_pkg::OUT_W-1:0]  res_neg_low_o,
  output logic signed [imwet_pkg::OUT_W-1:0]  res_high_o,
  output logic                                saturated_o
);

  localparam int unsigned W = imwet_pkg::OUT_W;

  // {clip, sum}
  function automatic logic [W:0] sat_add(input logic signed [W-1:0] a,
                                          input logic signed [W-1:0] b);
    logic signed [W-1:0] s;
    logic [W:0]          r;
    s = a + b;
    if ((a[W-1] == b[W-1]) && (s[W-1] != a[W-1])) begin
      r = {1'b1, a[W-1], {(W-1){~a[W-1]}}};
    end else begin
      r = {1'b0, s};
    end
    return r;
  endfunction

  logic signed [W-1:0] term_op, ofs_op;
  logic [W:0]          lo5_r, hi5_r, lo6_r, hi6_r;
  logic signed [W-1:0] lo5_q, hi5_q, lo6_q, hi6_q;
  logic                clip5_q, ofs5_q, clip6_q;

  assign term_op = err_en_i ? term_i : '0;
  assign lo5_r   = sat_add(lo_i, term_op);
  assign hi5_r   = sat_add(hi_i, term_op);

  assign ofs_op  = ofs5_q ? $signed({{(W - imwet_pkg::OFFSET_W){1'b0}}, constant_offset_i})
                          : '0;
  assign lo6_r   = sat_add(lo5_q, ofs_op);
  assign hi6_r   = sat_add(hi5_q, ofs_op);

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      lo5_q   <= lo5_r[W-1:0];
      hi5_q   <= hi5_r[W-1:0];
      clip5_q <= lo5_r[W] | hi5_r[W];
      ofs5_q  <= ofs_en_i;
    end
    if (en_i.s6) begin
      lo6_q   <= lo6_r[W-1:0];
      hi6_q   <= hi6_r[W-1:0];
      clip6_q <= clip5_q | lo6_r[W] | hi6_r[W];
    end
  end

  assign res_neg_low_o = lo6_q;
  assign res_high_o    = hi6_q;
  assign saturated_o   = clip6_q;

endmodule

>>> src/interval_multiply_with_error_term.sv
// Interval multiplier top level; instantiates imwet_cfg/prod/err/sat, uses imwet_pkg.
// Six register stages from accepted input word to result word.
// Throughput: one word per cycle unless stalled (fully pipelined multipliers, stages 1/2/4).
// A stalled output holds the last stage; empty stages upstream still fill (bubbles collapse).
// Reset (async, active low) clears all stage valid bits and loads the register defaults.
module interval_multiply_with_error_term (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [imwet_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   b_neg_low_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   b_high_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   c_neg_low_i,
  input  logic signed [imwet_pkg::IN_W-1:0]   c_high_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [imwet_pkg::OUT_W-1:0]  res_neg_low_o,
  output logic signed [imwet_pkg::OUT_W-1:0]  res_high_o,
  output logic                                saturated_o,
  // register writes
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_index_i,
  input  logic [imwet_pkg::CFG_W-1:0]         cfg_data_i
);

  // Stage map:
  //   1  four cross products, interval classes, max|c| and the scaled b bound
  //   2  bound selection (negate / max), max|c| * error factor
  //   3  round the error magnitude up to the input LSB
  //   4  error magnitude * b bound
  //   5  saturating add of the error term (modes 1..3)
  //   6  saturating add of the offset (mode bit 1), output register
  localparam int unsigned NSTG      = imwet_pkg::NSTG;
  localparam int unsigned MODE_TAPS = 4;

  logic [NSTG-1:0]                 vld_q, vld_d;
  logic [NSTG-1:0]                 adv;
  imwet_pkg::stage_en_t            en;
  logic [imwet_pkg::MODE_W-1:0]    mode_q [MODE_TAPS];

  logic [imwet_pkg::FACTOR_W-1:0]     error_factor;
  logic [imwet_pkg::OFFSET_W-1:0]     constant_offset;
  logic signed [imwet_pkg::OUT_W-1:0] lo_s4, hi_s4, term_s4;
  logic                               err_en, ofs_en;

  // A stage takes a new word when it is empty or its own word moves on.
  always_comb begin
    adv[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en.s1 = adv[0];
  assign en.s2 = adv[1];
  assign en.s3 = adv[2];
  assign en.s4 = adv[3];
  assign en.s5 = adv[4];
  assign en.s6 = adv[5];

  // mode rides alongside the datapath up to stage 4
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      mode_q[0] <= mode_i;
    end
    for (int k = 1; k < MODE_TAPS; k++) begin
      if (adv[k]) begin
        mode_q[k] <= mode_q[k-1];
      end
    end
  end

  // any nonzero mode adds the term; mode bit 1 adds the offset as well
  assign err_en = (mode_q[MODE_TAPS-1] != imwet_pkg::MODE_PLAIN);
  assign ofs_en = mode_q[MODE_TAPS-1][imwet_pkg::MODE_OFS_BIT];

  imwet_cfg u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .error_factor_o    (error_factor),
    .constant_offset_o (constant_offset)
  );

  imwet_prod u_prod (
    .clk_i       (clk_i),
    .en_i        (en),
    .b_neg_low_i (b_neg_low_i),
    .b_high_i    (b_high_i),
    .c_neg_low_i (c_neg_low_i),
    .c_high_i    (c_high_i),
    .lo_o        (lo_s4),
    .hi_o        (hi_s4)
  );

  imwet_err u_err (
    .clk_i          (clk_i),
    .en_i           (en),
    .b_neg_low_i    (b_neg_low_i),
    .b_high_i       (b_high_i),
    .c_neg_low_i    (c_neg_low_i),
    .c_high_i       (c_high_i),
    .error_factor_i (error_factor),
    .term_o         (term_s4)
  );

  imwet_sat u_sat (
    .clk_i             (clk_i),
    .en_i              (en),
    .lo_i              (lo_s4),
    .hi_i              (hi_s4),
    .term_i            (term_s4),
    .err_en_i          (err_en),
    .ofs_en_i          (ofs_en),
    .constant_offset_i (constant_offset),
    .res_neg_low_o     (res_neg_low_o),
    .res_high_o        (res_high_o),
    .saturated_o       (saturated_o)
  );

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NSTG-1];

endmodule

>>> src/imwet_chk.sv
// Port-level checker for the interval multiplier, bound to the top level.
// Depends on interval_multiply_with_error_term_defines.svh and imwet_pkg.
`include "interval_multiply_with_error_term_defines.svh"

module imwet_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [imwet_pkg::MODE_W-1:0]        mode_i,
  input logic signed [imwet_pkg::IN_W-1:0]   b_neg_low_i,
  input logic signed [imwet_pkg::IN_W-1:0]   b_high_i,
  input logic signed [imwet_pkg::IN_W-1:0]   c_neg_low_i,
  input logic signed [imwet_pkg::IN_W-1:0]   c_high_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [imwet_pkg::OUT_W-1:0]  res_neg_low_o,
  input logic signed [imwet_pkg::OUT_W-1:0]  res_high_o,
  input logic                                saturated_o,
  input logic                                cfg_we_i,
  input logic [0:0]                          cfg_index_i,
  input logic [imwet_pkg::CFG_W-1:0]         cfg_data_i
);

  // reset seen at an edge leaves no result word in the following cycle
  `IMWET_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "result valid after reset")

  // a stalled result word holds
  `IMWET_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(res_neg_low_o) && $stable(res_high_o) && $stable(saturated_o), "stalled result changed")

  // input back-pressure only when a result is held back
  `IMWET_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with output free")

  // an accepted input word yields a result word when the output never stalls
  `IMWET_ASSERT(a_latency, (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o, "result word missing after six cycles")

endmodule

bind interval_multiply_with_error_term imwet_chk u_imwet_chk (.*);
